FILE: rtl/dm64_pkg.sv
package dm64_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CNT_W  = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    CMD_DIVU = 2'd0,
    CMD_REMU = 2'd1,
    CMD_DIVS = 2'd2,
    CMD_REMS = 2'd3
  } cmd_t;

  typedef struct packed {
    word_t rem;
    logic  qbit;
  } step_out_t;

endpackage

FILE: rtl/dm64_step.sv
module dm64_step
  import dm64_pkg::*;
(
  input  word_t     rem,
  input  logic      nbit,
  input  word_t     dvsr,
  output step_out_t res
);

  logic [WORD_W:0] shifted;
  logic            fits;

  always_comb begin
    shifted = {rem, nbit};
    fits    = (shifted >= {1'b0, dvsr});
    res.qbit = fits;
    if (fits) begin
      res.rem = shifted[WORD_W-1:0] - dvsr;
    end else begin
      res.rem = shifted[WORD_W-1:0];
    end
  end

endmodule

FILE: rtl/divide_modulo_64bit.sv
// 64-bit divide / modulo unit, restoring shift-and-subtract on magnitudes.
// request channel: cmd, dividend and divisor are taken at a rising edge
//   where start is high and busy is low; busy then stays high until the
//   result is out.
// cmd selects unsigned quotient, unsigned remainder, signed quotient or
//   signed remainder. a zero divisor gives a result of 0.
// result channel: result is valid for exactly one cycle while done is high.
//   the receiver cannot stall it; it must take the value in that cycle.
// sequence: ST_PREP forms the operand magnitudes, the shift-subtract loop
//   in ST_DIV gives one quotient bit per cycle through a single
//   64-bit compare/subtract, and ST_FIX applies the sign. done rises
//   at the same edge at which busy falls, so a new request is taken only
//   once the last one is through. a zero divisor skips the loop, going
//   from ST_PREP straight to ST_FIX.
// reset: rst is synchronous, active high; it returns the sequencer to idle
//   and clears done. no state is kept between requests.
module divide_modulo_64bit
  import dm64_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [WORD_W-1:0]   dividend,
  input  logic [WORD_W-1:0]   divisor,
  output logic                done,
  output logic [WORD_W-1:0]   result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIX  = 4'b1000
  } state_t;

  state_t    state;
  cnt_t      count;
  word_t     a_raw;
  word_t     b_raw;
  logic      is_signed;
  logic      want_rem;
  logic      a_neg;
  logic      b_neg;
  logic      zero_div;
  word_t     nq;
  word_t     rem;
  word_t     dvsr;
  word_t     fix_val;
  logic      fix_neg;
  step_out_t step;

  dm64_step u_step (
    .rem  (rem),
    .nbit (nq[WORD_W-1]),
    .dvsr (dvsr),
    .res  (step)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    if (want_rem) begin
      fix_val = rem;
      fix_neg = a_neg;
    end else begin
      fix_val = nq;
      fix_neg = a_neg ^ b_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          count <= '1;
          if (b_raw == '0) begin
            state <= ST_FIX;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          count <= count - 1'b1;
          if (count == '0) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          a_raw     <= dividend;
          b_raw     <= divisor;
          is_signed <= (cmd == CMD_DIVS) || (cmd == CMD_REMS);
          want_rem  <= (cmd == CMD_REMU) || (cmd == CMD_REMS);
        end
      end
      ST_PREP: begin
        a_neg    <= is_signed & a_raw[WORD_W-1];
        b_neg    <= is_signed & b_raw[WORD_W-1];
        zero_div <= (b_raw == '0);
        nq       <= (is_signed & a_raw[WORD_W-1]) ? (word_t'(0) - a_raw) : a_raw;
        dvsr     <= (is_signed & b_raw[WORD_W-1]) ? (word_t'(0) - b_raw) : b_raw;
        rem      <= '0;
      end
      ST_DIV: begin
        rem <= step.rem;
        nq  <= {nq[WORD_W-2:0], step.qbit};
      end
      ST_FIX: begin
        if (zero_div) begin
          result <= '0;
        end else if (fix_neg) begin
          result <= word_t'(0) - fix_val;
        end else begin
          result <= fix_val;
        end
      end
      default: begin
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_PREP))
    else $error("request not taken");

  a_loop_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && count == '0) |=> (state == ST_FIX))
    else $error("divide loop did not end after 64 steps");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state == ST_FIX))
    else $error("done without sign fix step");

endmodule

FILE: tb/tb_divide_modulo_64bit.sv
`timescale 1ns / 1ps

module tb_divide_modulo_64bit;
  import dm64_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEMS_PER_PHASE = 645;
  localparam word_t MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t ALL_ONES = '1;

  class divmod_scoreboard;
    word_t expected_q[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    function word_t divmod_expected(cmd_t op, word_t a, word_t b);
      logic is_signed;
      logic want_rem;
      logic a_neg;
      logic b_neg;
      word_t ua;
      word_t ub;
      is_signed = (op == CMD_DIVS) || (op == CMD_REMS);
      want_rem = (op == CMD_REMU) || (op == CMD_REMS);
      a_neg = is_signed && a[WORD_W-1];
      b_neg = is_signed && b[WORD_W-1];
      ua = a_neg ? word_t'(0) - a : a;
      ub = b_neg ? word_t'(0) - b : b;
      if (ub == '0) return '0;
      if (want_rem) return a_neg ? word_t'(0) - (ua % ub) : ua % ub;
      return (a_neg != b_neg) ? word_t'(0) - (ua / ub) : ua / ub;
    endfunction

    function void note_request(cmd_t op, word_t a, word_t b);
      expected_q.push_back(divmod_expected(op, a, b));
    endfunction

    function void check_result(word_t actual);
      word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, actual);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (actual !== want) begin
        $display("%0t: result mismatch, expected %h actual %h", $time, want, actual);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_DIVU;
  logic [WORD_W-1:0] dividend = '0;
  logic [WORD_W-1:0] divisor = '0;
  logic busy;
  logic done;
  logic [WORD_W-1:0] result;
  int unsigned cycle_count = 0;
  divmod_scoreboard sb = new();

  divide_modulo_64bit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .dividend(dividend),
    .divisor(divisor),
    .done(done),
    .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_divide_modulo_64bit NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(result);
    end
  end

  task automatic send_request(cmd_t op, word_t a, word_t b);
    start <= 1'b1;
    cmd <= op;
    dividend <= a;
    divisor <= b;
    do @(posedge clk); while (busy);
    sb.note_request(op, a, b);
  endtask

  task automatic pause_requests(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic word_t rand_operand();
    word_t v;
    int unsigned w;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 6))
      0, 1: begin
        w = $urandom_range(1, WORD_W);
        if (w < WORD_W) v = v & ((word_t'(1) << w) - 1);
      end
      2: v = word_t'($urandom_range(0, 15));
      3: v = word_t'(0) - word_t'($urandom_range(1, 15));
      4: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = word_t'(1);
          2: v = ALL_ONES;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random(int unsigned count, int unsigned idle_pct);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      send_request(cmd_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
      if ($urandom_range(0, 99) < idle_pct) pause_requests($urandom_range(1, 90));
    end
  endtask

  initial begin
    word_t pair_a[6];
    word_t pair_b[6];
    int unsigned c;
    int unsigned k;
    // zero divisor, most negative over minus one, divisor above dividend, mixed signs
    pair_a = '{ALL_ONES, MOST_NEG, 64'd5, ALL_ONES, word_t'(0) - 64'd7, 64'd100};
    pair_b = '{64'd0, ALL_ONES, 64'd7, 64'd1, 64'd2, word_t'(0) - 64'd3};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (c = 0; c < 4; c++) begin
      for (k = 0; k < 6; k++) begin
        send_request(cmd_t'(c), pair_a[k], pair_b[k]);
      end
    end
    wait_drained();
    @(posedge clk);
    run_random(ITEMS_PER_PHASE, 31);
    wait_drained();
    @(posedge clk);
    run_random(ITEMS_PER_PHASE, 64);
    wait_drained();
    @(posedge clk);
    run_random(ITEMS_PER_PHASE, 0);
    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb_divide_modulo_64bit OK");
    end else begin
      $display("tb_divide_modulo_64bit NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dm64_pkg.sv
rtl/dm64_step.sv
rtl/divide_modulo_64bit.sv
tb/tb_divide_modulo_64bit.sv
